>>> hw/rtl/ftat_pkg.sv
package ftat_pkg;

  typedef logic [63:0] tick_t;
  typedef logic [31:0] ip_t;
  typedef logic [15:0] port_t;
  typedef logic [7:0]  proto_t;
  typedef logic [6:0]  count_t;
  typedef logic [63:0] addr_key_t;
  typedef logic [39:0] pp_key_t;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_AGE  = 1'b1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam proto_t PROTO_TCP = 8'd6;
  localparam proto_t PROTO_UDP = 8'd17;

  localparam tick_t  HOLD_RESET = 64'd100000000;
  localparam tick_t  AGE_RESET  = 64'd1200000000;
  localparam count_t COUNT_MAX  = 7'd127;

  typedef struct packed {
    logic   op;
    tick_t  now;
    proto_t protocol;
    ip_t    src_ip;
    ip_t    dst_ip;
    port_t  src_port;
    port_t  dst_port;
  } req_t;

  typedef struct packed {
    logic      valid;
    addr_key_t addr;
    pp_key_t   pp;
    tick_t     stamp;
  } entry_t;

  typedef struct packed {
    logic   send_auth;
    logic   known_flow;
    logic   table_full;
    count_t removed_count;
  } res_t;

  typedef struct packed {
    logic clear_wr;
    logic req_load;
    logic scan_init;
    logic rd_en;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic proto_ok;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/ftat_if.sv
interface ftat_in_if;
  import ftat_pkg::*;

  logic   valid;
  logic   ready;
  logic   op;
  tick_t  now;
  proto_t protocol;
  ip_t    src_ip;
  ip_t    dst_ip;
  port_t  src_port;
  port_t  dst_port;

  modport source (output valid, op, now, protocol, src_ip, dst_ip, src_port, dst_port,
                  input ready);
  modport sink (input valid, op, now, protocol, src_ip, dst_ip, src_port, dst_port,
                output ready);
endinterface

interface ftat_out_if;
  import ftat_pkg::*;

  logic   valid;
  logic   ready;
  logic   send_auth;
  logic   known_flow;
  logic   table_full;
  count_t removed_count;

  modport source (output valid, send_auth, known_flow, table_full, removed_count,
                  input ready);
  modport sink (input valid, send_auth, known_flow, table_full, removed_count,
                output ready);
endinterface

>>> hw/rtl/ftat_regs.sv
module ftat_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftat_pkg::CFG_AW-1:0] paddr,
  input  logic [ftat_pkg::CFG_DW-1:0] pwdata,
  output logic [ftat_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output ftat_pkg::tick_t             hold_ticks,
  output ftat_pkg::tick_t             age_limit_ticks
);
  import ftat_pkg::*;

  tick_t hold_r;
  tick_t age_r;
  logic  sel;

  assign sel    = paddr[REG_SEL_BIT];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
      age_r  <= AGE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_HOLD: hold_r <= pwdata;
        REG_AGE:  age_r  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_HOLD: prdata = hold_r;
      REG_AGE:  prdata = age_r;
    endcase
  end

  assign hold_ticks      = hold_r;
  assign age_limit_ticks = age_r;

endmodule

>>> hw/rtl/ftat_ctrl.sv
module ftat_ctrl #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ftat_pkg::stat_t                  st,
  output ftat_pkg::cmd_t                   cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);
  import ftat_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          issued_r, issued_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    issued_nxt = issued_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_START;
        end
      end
      ST_START: begin
        cmd.scan_init = 1'b1;
        cnt_nxt       = '0;
        issued_nxt    = 1'b0;
        // Packets that are neither TCP nor UDP never touch the table.
        if (!st.is_sweep && !st.proto_ok) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.rd_en = !issued_r;
        if (!issued_r) begin
          if (cnt_r == LAST_IDX) begin
            issued_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (st.hit || st.last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign idx = cnt_r;

endmodule

>>> hw/rtl/ftat_dp.sv
module ftat_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ftat_pkg::cmd_t                   cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx,
  output ftat_pkg::stat_t                  st,
  input  ftat_pkg::req_t                   req,
  input  ftat_pkg::tick_t                  hold_ticks,
  input  ftat_pkg::tick_t                  age_limit_ticks,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ftat_pkg::res_t                   res
);
  import ftat_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];

  req_t      req_r;
  entry_t    rd_data_r;
  logic      ev_en_r;
  logic [IW-1:0] ev_idx_r;
  logic      hit_found_r;
  logic      hit_auth_r;
  logic [IW-1:0] hit_idx_r;
  logic      free_found_r;
  logic [IW-1:0] free_idx_r;
  count_t    count_r;
  logic      out_valid_r;
  res_t      res_r, res_nxt;

  addr_key_t addr_key;
  pp_key_t   pp_key;
  tick_t     age;
  tick_t     limit;
  logic      eval;
  logic      key_hit;
  logic      expire;
  logic      proto_ok;
  logic      wr_en;
  logic [IW-1:0] wr_idx;
  entry_t    wr_data;

  assign addr_key = {req_r.src_ip, req_r.dst_ip};
  assign pp_key   = {req_r.src_port, req_r.dst_port, req_r.protocol};
  assign proto_ok = (req_r.protocol == PROTO_TCP) || (req_r.protocol == PROTO_UDP);

  // Age is taken modulo 2^64, so a clock that has wrapped reads as very old.
  assign age   = req_r.now - rd_data_r.stamp;
  assign limit = (req_r.op == OP_SWEEP) ? age_limit_ticks : hold_ticks;
  assign eval  = cmd.scan && ev_en_r;

  assign key_hit = eval && (req_r.op == OP_LOOKUP) && rd_data_r.valid &&
                   (rd_data_r.addr == addr_key) && (rd_data_r.pp == pp_key);
  assign expire  = eval && (req_r.op == OP_SWEEP) && rd_data_r.valid && (age >= limit);

  always_comb begin
    st.is_sweep = (req_r.op == OP_SWEEP);
    st.proto_ok = proto_ok;
    st.hit      = key_hit;
    st.last     = ev_en_r && (ev_idx_r == LAST_IDX);
    st.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_en_r <= 1'b0;
    end else begin
      ev_en_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      count_r      <= '0;
    end else if (cmd.scan_init) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      count_r      <= '0;
    end else if (eval) begin
      if (key_hit) begin
        hit_found_r <= 1'b1;
      end else if ((req_r.op == OP_LOOKUP) && !rd_data_r.valid && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (expire && (count_r != COUNT_MAX)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_hit) begin
      hit_idx_r  <= ev_idx_r;
      hit_auth_r <= (age >= limit);
    end
    if (eval && (req_r.op == OP_LOOKUP) && !rd_data_r.valid && !free_found_r) begin
      free_idx_r <= ev_idx_r;
    end
  end

  always_comb begin
    res_nxt = '0;
    wr_en   = 1'b0;
    wr_idx  = idx;
    wr_data = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (expire) begin
      wr_en         = 1'b1;
      wr_idx        = ev_idx_r;
      wr_data       = rd_data_r;
      wr_data.valid = 1'b0;
    end
    if (req_r.op == OP_SWEEP) begin
      res_nxt.removed_count = count_r;
    end else if (proto_ok) begin
      res_nxt.send_auth = 1'b1;
      wr_data.valid     = 1'b1;
      wr_data.addr      = addr_key;
      wr_data.pp        = pp_key;
      wr_data.stamp     = req_r.now;
      if (hit_found_r) begin
        res_nxt.known_flow = 1'b1;
        res_nxt.send_auth  = hit_auth_r;
        wr_idx             = hit_idx_r;
        wr_en              = cmd.finish && hit_auth_r;
      end else if (free_found_r) begin
        wr_idx = free_idx_r;
        wr_en  = cmd.finish;
      end else begin
        res_nxt.table_full = 1'b1;
      end
      if (cmd.clear_wr) begin
        wr_en   = 1'b1;
        wr_idx  = idx;
        wr_data = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> hw/rtl/flow_table_auth_throttle_core.sv
// Channel  | Direction | Handshake     | Carries
// in_ch    | sink      | valid / ready | op, now, protocol, addresses, ports
// out_ch   | source    | valid / ready | send_auth, known_flow, table_full, removed_count
// APB      | slave     | psel/penable  | hold_ticks at 0x0, age_limit_ticks at 0x8
//
// After reset the table is cleared entry by entry; in_ch.ready stays low meanwhile.
// A lookup scans the entry memory one entry per cycle through its single read port: it
// stops at the first entry that hits and otherwise reads every entry. A sweep reads every
// entry; a packet that is neither TCP nor UDP skips the scan. A new request is taken while
// the previous result waits in the output register; a stalled output only holds up the end
// of the following request.
module flow_table_auth_throttle_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ftat_in_if.sink                     in_ch,
  ftat_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftat_pkg::CFG_AW-1:0] paddr,
  input  logic [ftat_pkg::CFG_DW-1:0] pwdata,
  output logic [ftat_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ftat_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);

  tick_t         hold_ticks;
  tick_t         age_limit_ticks;
  cmd_t          cmd;
  stat_t         st;
  logic [IW-1:0] idx;
  logic          in_ready;
  logic          out_valid;
  req_t          req;
  res_t          res;

  ftat_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .hold_ticks      (hold_ticks),
    .age_limit_ticks (age_limit_ticks)
  );

  ftat_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd),
    .idx      (idx)
  );

  always_comb begin
    req.op       = in_ch.op;
    req.now      = in_ch.now;
    req.protocol = in_ch.protocol;
    req.src_ip   = in_ch.src_ip;
    req.dst_ip   = in_ch.dst_ip;
    req.src_port = in_ch.src_port;
    req.dst_port = in_ch.dst_port;
  end

  ftat_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .st              (st),
    .req             (req),
    .hold_ticks      (hold_ticks),
    .age_limit_ticks (age_limit_ticks),
    .out_valid       (out_valid),
    .out_ready       (out_ch.ready),
    .res             (res)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.send_auth     = res.send_auth;
  assign out_ch.known_flow    = res.known_flow;
  assign out_ch.table_full    = res.table_full;
  assign out_ch.removed_count = res.removed_count;

endmodule

>>> hw/rtl/ftat_checker.sv
module ftat_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   send_auth,
  input logic                   known_flow,
  input logic                   table_full,
  input ftat_pkg::count_t       removed_count
);
  import ftat_pkg::*;

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one was still in progress");

  a_full_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> send_auth && !known_flow)
    else $error("table_full result without authorisation or on a known flow");

  a_packet_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (send_auth || known_flow || table_full) |-> removed_count == '0)
    else $error("packet result carries a removed count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(send_auth) && $stable(known_flow) &&
                                $stable(table_full) && $stable(removed_count))
    else $error("stalled result changed or was dropped");

endmodule

bind flow_table_auth_throttle_core ftat_checker u_ftat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .send_auth     (out_ch.send_auth),
  .known_flow    (out_ch.known_flow),
  .table_full    (out_ch.table_full),
  .removed_count (out_ch.removed_count)
);

>>> tb/flow_table_auth_throttle_core_test.sv
module flow_table_auth_throttle_core_test;
  import ftat_pkg::*;

  localparam int          FLOW_SLOTS  = 64;
  localparam int          POOL_SIZE   = 80;
  localparam int          PHASE_ITEMS = 200;
  localparam int          MAX_REPORTS = 40;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    proto_t protocol;
    ip_t    src_ip;
    ip_t    dst_ip;
    port_t  src_port;
    port_t  dst_port;
  } flow_key_t;

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  ftat_in_if  in_ch();
  ftat_out_if out_ch();

  flow_table_auth_throttle_core #(
    .TABLE_ENTRIES(FLOW_SLOTS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the flow table and its two registers.
  tick_t     hold_cfg;
  tick_t     age_cfg;
  logic      flow_valid [FLOW_SLOTS];
  addr_key_t flow_addr  [FLOW_SLOTS];
  pp_key_t   flow_pp    [FLOW_SLOTS];
  tick_t     flow_stamp [FLOW_SLOTS];

  req_t        pending_reqs[$];
  res_t        results_due[$];
  flow_key_t   flow_pool[POOL_SIZE];
  req_t        next_req;
  req_t        taken_req;
  logic        in_taken;
  bit          calm_phase;
  int          send_gap;
  int          stall_left;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic res_t predict_request(input req_t rq);
    res_t      rs;
    addr_key_t akey;
    pp_key_t   pkey;
    int        hit_idx;
    int        free_idx;
    rs = '0;
    hit_idx = -1;
    free_idx = -1;
    if (rq.op == OP_SWEEP) begin
      for (int i = 0; i < FLOW_SLOTS; i++) begin
        if (flow_valid[i] && tick_t'(rq.now - flow_stamp[i]) >= age_cfg) begin
          flow_valid[i] = 1'b0;
          if (rs.removed_count != COUNT_MAX) rs.removed_count++;
        end
      end
      return rs;
    end
    if (rq.protocol != PROTO_TCP && rq.protocol != PROTO_UDP) return rs;
    akey = {rq.src_ip, rq.dst_ip};
    pkey = {rq.src_port, rq.dst_port, rq.protocol};
    for (int i = 0; i < FLOW_SLOTS; i++) begin
      if (flow_valid[i]) begin
        if (hit_idx < 0 && flow_addr[i] == akey && flow_pp[i] == pkey) hit_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit_idx >= 0) begin
      rs.known_flow = 1'b1;
      if (tick_t'(rq.now - flow_stamp[hit_idx]) >= hold_cfg) begin
        flow_stamp[hit_idx] = rq.now;
        rs.send_auth = 1'b1;
      end
    end else if (free_idx >= 0) begin
      flow_valid[free_idx] = 1'b1;
      flow_addr[free_idx]  = akey;
      flow_pp[free_idx]    = pkey;
      flow_stamp[free_idx] = rq.now;
      rs.send_auth = 1'b1;
    end else begin
      rs.send_auth  = 1'b1;
      rs.table_full = 1'b1;
    end
    return rs;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic queue_req(input req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  task automatic check_result();
    res_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = results_due.pop_front();
    if (out_ch.send_auth !== want.send_auth)
      report_mismatch($sformatf("send_auth %b, expected %b", out_ch.send_auth, want.send_auth));
    if (out_ch.known_flow !== want.known_flow)
      report_mismatch($sformatf("known_flow %b, expected %b", out_ch.known_flow,
                                want.known_flow));
    if (out_ch.table_full !== want.table_full)
      report_mismatch($sformatf("table_full %b, expected %b", out_ch.table_full,
                                want.table_full));
    if (out_ch.removed_count !== want.removed_count)
      report_mismatch($sformatf("removed_count %0d, expected %0d", out_ch.removed_count,
                                want.removed_count));
  endtask

  // Prediction and checking both happen at the rising edge; an output can never belong to
  // the request taken at the same edge, so the order of the two is safe.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("flow_table_auth_throttle_core_test: errors");
      $finish;
    end else if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) begin
        taken_req.op       = in_ch.op;
        taken_req.now      = in_ch.now;
        taken_req.protocol = in_ch.protocol;
        taken_req.src_ip   = in_ch.src_ip;
        taken_req.dst_ip   = in_ch.dst_ip;
        taken_req.src_port = in_ch.src_port;
        taken_req.dst_port = in_ch.dst_port;
        results_due.insert(results_due.size(), predict_request(taken_req));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // The current request is still waiting to be taken.
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap--;
    end else if (pending_reqs.size() != 0) begin
      next_req = pending_reqs.pop_front();
      in_ch.op       <= next_req.op;
      in_ch.now      <= next_req.now;
      in_ch.protocol <= next_req.protocol;
      in_ch.src_ip   <= next_req.src_ip;
      in_ch.dst_ip   <= next_req.dst_ip;
      in_ch.src_port <= next_req.src_port;
      in_ch.dst_port <= next_req.dst_port;
      in_ch.valid    <= 1'b1;
      send_gap = calm_phase ? 0 : pick_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = calm_phase ? 0 : pick_gap();
    end
  end

  function automatic req_t make_req(input logic op, input tick_t now, input proto_t protocol,
                                    input ip_t sip, input ip_t dip,
                                    input port_t sport, input port_t dport);
    req_t rq;
    rq.op       = op;
    rq.now      = now;
    rq.protocol = protocol;
    rq.src_ip   = sip;
    rq.dst_ip   = dip;
    rq.src_port = sport;
    rq.dst_port = dport;
    return rq;
  endfunction

  function automatic flow_key_t fresh_flow();
    flow_key_t k;
    k.protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    k.src_ip   = $urandom;
    k.dst_ip   = $urandom;
    k.src_port = port_t'($urandom);
    k.dst_port = port_t'($urandom);
    return k;
  endfunction

  // The upper part of the pool holds near misses: copies of other flows with one key field
  // disturbed, so that a partial key match must not count as a hit.
  task automatic build_pool();
    flow_key_t k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < FLOW_SLOTS) begin
        flow_pool[i] = fresh_flow();
      end else begin
        k = flow_pool[i - FLOW_SLOTS];
        case ($urandom_range(0, 4))
          0: k.protocol = (k.protocol == PROTO_TCP) ? PROTO_UDP : PROTO_TCP;
          1: k.src_ip   ^= 32'd1 << $urandom_range(0, 31);
          2: k.dst_ip   ^= 32'd1 << $urandom_range(0, 31);
          3: k.src_port ^= 16'd1 << $urandom_range(0, 15);
          default: k.dst_port ^= 16'd1 << $urandom_range(0, 15);
        endcase
        flow_pool[i] = k;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input tick_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << REG_SEL_BIT;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HOLD: hold_cfg = value;
      REG_AGE:  age_cfg  = value;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sampled at the rising edge, where the driver's last update has settled.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input tick_t hold, input tick_t age, input int unsigned step_max,
                           input bit calm);
    tick_t       clock_now;
    tick_t       stamp_at;
    flow_key_t   k;
    int unsigned roll;
    int unsigned slot;
    wait_idle();
    write_reg(REG_HOLD, hold);
    write_reg(REG_AGE, age);
    calm_phase = calm;
    clock_now = {$urandom, $urandom};
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      clock_now += tick_t'($urandom_range(0, step_max));
      stamp_at = ($urandom_range(0, 99) < 3) ? {$urandom, $urandom} : clock_now;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_req(make_req(OP_SWEEP, stamp_at, proto_t'($urandom), $urandom, $urandom,
                           port_t'($urandom), port_t'($urandom)));
      end else if (roll < 14) begin
        queue_req(make_req(OP_LOOKUP, stamp_at, proto_t'($urandom_range(0, 255)),
                           $urandom, $urandom, port_t'($urandom), port_t'($urandom)));
      end else begin
        slot = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 2) flow_pool[slot] = fresh_flow();
        k = flow_pool[slot];
        queue_req(make_req(OP_LOOKUP, stamp_at, k.protocol, k.src_ip, k.dst_ip,
                           k.src_port, k.dst_port));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_LOOKUP;
    in_ch.now       = '0;
    in_ch.protocol  = '0;
    in_ch.src_ip    = '0;
    in_ch.dst_ip    = '0;
    in_ch.src_port  = '0;
    in_ch.dst_port  = '0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_taken        = 1'b0;
    calm_phase      = 1'b0;
    send_gap        = 0;
    stall_left      = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    hold_cfg        = HOLD_RESET;
    age_cfg         = AGE_RESET;
    for (int i = 0; i < FLOW_SLOTS; i++) flow_valid[i] = 1'b0;
    build_pool();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under the reset register values.
    queue_req(make_req(OP_LOOKUP, 64'd1000, PROTO_TCP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    queue_req(make_req(OP_LOOKUP, 64'd2000, PROTO_TCP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    // Exactly the hold time after the first authorisation.
    queue_req(make_req(OP_LOOKUP, 64'd1000 + HOLD_RESET, PROTO_TCP,
                       32'h0A000001, 32'h0A000002, 16'd1234, 16'd80));
    // Time running backwards wraps into a very large age.
    queue_req(make_req(OP_LOOKUP, 64'd5, PROTO_TCP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    queue_req(make_req(OP_LOOKUP, '1, PROTO_UDP, '1, '1, '1, '1));
    queue_req(make_req(OP_LOOKUP, '0, PROTO_TCP, '0, '0, '0, '0));
    queue_req(make_req(OP_LOOKUP, 64'd10, PROTO_UDP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    queue_req(make_req(OP_LOOKUP, 64'd20, 8'd0, 32'h0A000001, 32'h0A000002,
                       16'd1234, 16'd80));
    queue_req(make_req(OP_LOOKUP, 64'd30, 8'd255, '1, '1, '1, '1));
    queue_req(make_req(OP_LOOKUP, 64'd40, 8'd7, 32'h0A000001, 32'h0A000002,
                       16'd1234, 16'd80));
    queue_req(make_req(OP_LOOKUP, 64'd50, 8'd16, '0, '0, '0, '0));
    queue_req(make_req(OP_SWEEP, 64'd60, PROTO_TCP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    // One tick short of the age limit for the first flow, past it for the flows stamped 0 and all ones.
    queue_req(make_req(OP_SWEEP, 64'd4 + AGE_RESET, '0, '0, '0, '0, '0));
    queue_req(make_req(OP_SWEEP, 64'd5 + AGE_RESET, '1, '1, '1, '1, '1));
    queue_req(make_req(OP_LOOKUP, 64'd6 + AGE_RESET, PROTO_TCP, 32'h0A000001,
                       32'h0A000002, 16'd1234, 16'd80));
    queue_req(make_req(OP_SWEEP, '1, '0, '0, '0, '0, '0));
    queue_req(make_req(OP_LOOKUP, 64'h8000_0000_0000_0000, PROTO_UDP,
                       32'h8000_0001, 32'h0000_8000, 16'h8001, 16'h0100));
    queue_req(make_req(OP_SWEEP, '0, '0, '0, '0, '0, '0));

    run_phase(HOLD_RESET, AGE_RESET, 200000000, 1'b0);
    run_phase('0, '0, 50, 1'b1);
    run_phase('1, '1, 100000, 1'b0);
    run_phase(64'd40, 64'd300, 30, 1'b0);
    run_phase(tick_t'($urandom_range(0, 5000)), {$urandom, $urandom}, 1000, 1'b1);
    run_phase(64'd1000, 64'd5000, 200, 1'b0);

    wait_idle();
    repeat (FLOW_SLOTS + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("flow_table_auth_throttle_core_test: clean");
    end else begin
      $display("flow_table_auth_throttle_core_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ftat_pkg.sv
hw/rtl/ftat_if.sv
hw/rtl/ftat_regs.sv
hw/rtl/ftat_ctrl.sv
hw/rtl/ftat_dp.sv
hw/rtl/flow_table_auth_throttle_core.sv
hw/rtl/ftat_checker.sv
tb/flow_table_auth_throttle_core_test.sv
